/* rtl/core/gdr_pkg.sv */
// Shared types, register indexes and constants of the column raycaster.
package gdr_pkg;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_SCR_W   = 3'd6;
  localparam logic [2:0] REG_SCR_H   = 3'd7;

  localparam int CFG_W = 21;

  localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
  localparam logic [10:0] ROW_MAX    = 11'd2047;

  typedef struct packed {
    logic        mode;
    logic [10:0] column;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic        wall_bit;
  } item_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic        hit;
    logic        hit_side;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [23:0] perp_dist;
    logic [15:0] line_height;
    logic [10:0] draw_start;
    logic [10:0] draw_end;
  } result_t;

  typedef enum logic [2:0] {
    DIV_CAM  = 3'd0,
    DIV_DX   = 3'd1,
    DIV_DY   = 3'd2,
    DIV_PERP = 3'd3,
    DIV_LH   = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic     clr_en;
    logic     map_wr;
    logic     cap_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     ray;
    logic     side_init;
    logic     step;
    logic     rd;
    logic     miss;
    logic     draw;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic in_map;
    logic oob;
    logic wall;
    logic walk_end;
  } status_t;

endpackage

/* rtl/core/gdr_div.sv */
// Restoring divider that resolves one quotient bit per cycle.
module gdr_div #(
  parameter int DVW = 40,
  parameter int DSW = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [DVW-1:0] acc;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [DSW:0]   shifted;
  logic [DSW:0]   trial;
  logic           ge;

  assign shifted  = {rem, acc[DVW-1]};
  assign ge       = shifted >= {1'b0, dsr};
  assign trial    = shifted - {1'b0, dsr};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[DSW-1:0] : shifted[DSW-1:0];
      acc <= {acc[DVW-2:0], ge};
    end
  end

endmodule

/* rtl/core/gdr_dp.sv */
// Datapath: registers, wall map memory, ray setup, grid walk and result word.
module gdr_dp #(
  parameter int MAP_DIM = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0]  cfg_data,
  input  gdr_pkg::item_t             item,
  input  gdr_pkg::cmd_t              cmd,
  output gdr_pkg::status_t           st,
  output gdr_pkg::result_t           result
);

  import gdr_pkg::*;

  localparam int IW       = $clog2(MAP_DIM) + 2;
  localparam int CELLS    = MAP_DIM * MAP_DIM;
  localparam int AW       = $clog2(CELLS);
  localparam int NW       = $clog2(2 * MAP_DIM + 3);
  localparam int WALK_LIM = 2 * MAP_DIM + 2;
  localparam int SW       = 26 + NW;
  localparam int EW       = IW + 17;
  localparam int DVW      = (EW + 16 > 33) ? EW + 16 : 33;

  function automatic logic [23:0] sat24(input logic [DVW-1:0] q);
    return (q > DVW'(DIST_MAX)) ? DIST_MAX : q[23:0];
  endfunction

  // Configuration registers.
  logic        [20:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic        [11:0] scr_w, scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 21'd0;
      pos_y   <= 21'd0;
      dir_x   <= 16'sd16384;
      dir_y   <= 16'sd0;
      plane_x <= 16'sd0;
      plane_y <= 16'sd10813;
      scr_w   <= 12'd640;
      scr_h   <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:   pos_x   <= cfg_data[20:0];
        REG_POS_Y:   pos_y   <= cfg_data[20:0];
        REG_DIR_X:   dir_x   <= signed'(cfg_data[15:0]);
        REG_DIR_Y:   dir_y   <= signed'(cfg_data[15:0]);
        REG_PLANE_X: plane_x <= signed'(cfg_data[15:0]);
        REG_PLANE_Y: plane_y <= signed'(cfg_data[15:0]);
        REG_SCR_W:   scr_w   <= cfg_data[11:0];
        REG_SCR_H:   scr_h   <= cfg_data[11:0];
        default:     ;
      endcase
    end
  end

  logic [11:0] w_eff, h_eff;
  assign w_eff = (scr_w == 12'd0) ? 12'd1 : scr_w;
  assign h_eff = (scr_h == 12'd0) ? 12'd1 : scr_h;

  // Working registers of one cast.
  logic        [10:0]   column;
  logic signed [29:0]   cam;
  logic signed [31:0]   rx, ry;
  logic        [23:0]   ddx, ddy;
  logic        [SW-1:0] sdx, sdy;
  logic signed [IW-1:0] mx, my;
  logic                 side, hit, in_map;
  logic        [NW-1:0] n;
  logic        [23:0]   perp;
  logic        [15:0]   lh;
  logic        [10:0]   ds, de;
  div_sel_t             sel_q;

  logic [31:0] arx, ary;
  assign arx = rx[31] ? 32'(-rx) : 32'(rx);
  assign ary = ry[31] ? 32'(-ry) : 32'(ry);

  // Distance from the viewer to the crossed cell edge, for the perpendicular distance.
  logic signed [IW-1:0] mxs;
  logic                 neg_s;
  logic signed [EW-1:0] pos_e, edge_e, e_val;
  logic        [EW-1:0] e_abs;

  always_comb begin
    mxs    = side ? my : mx;
    neg_s  = side ? ry[31] : rx[31];
    pos_e  = EW'($signed({1'b0, (side ? pos_y : pos_x)}));
    edge_e = EW'(mxs) <<< 16;
    if (neg_s) begin
      e_val = pos_e - (edge_e + (EW'(1) <<< 16));
    end else begin
      e_val = edge_e - pos_e;
    end
    e_abs = e_val[EW-1] ? EW'(-e_val) : EW'(e_val);
  end

  // Shared divider.
  logic [DVW-1:0] dvd, quo;
  logic [31:0]    dsr;
  logic           div_done;

  always_comb begin
    case (cmd.div_sel)
      DIV_CAM: begin
        dvd = DVW'({column, 17'd0});
        dsr = 32'(w_eff);
      end
      DIV_DX: begin
        dvd = DVW'(33'h1_0000_0000);
        dsr = arx;
      end
      DIV_DY: begin
        dvd = DVW'(33'h1_0000_0000);
        dsr = ary;
      end
      DIV_PERP: begin
        dvd = DVW'({e_abs, 16'd0});
        dsr = side ? ary : arx;
      end
      DIV_LH: begin
        dvd = DVW'({h_eff, 16'd0});
        dsr = 32'(perp);
      end
      default: begin
        dvd = '0;
        dsr = 32'd1;
      end
    endcase
  end

  gdr_div #(
    .DVW (DVW),
    .DSW (32)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  // Ray components.
  logic signed [45:0] prod_x, prod_y;
  assign prod_x = 46'(plane_x) * 46'(cam);
  assign prod_y = 46'(plane_y) * 46'(cam);

  // Initial side distances.
  logic [16:0] fsel_x, fsel_y;
  logic [40:0] side_px, side_py;
  assign fsel_x  = rx[31] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
  assign fsel_y  = ry[31] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
  assign side_px = 41'(fsel_x) * 41'(ddx);
  assign side_py = 41'(fsel_y) * 41'(ddy);

  // Slice rows.
  logic [10:0] h2;
  logic [14:0] l2;
  logic [15:0] de_sum;
  logic [15:0] de_clip;
  assign h2     = h_eff[11:1];
  assign l2     = lh[15:1];
  assign de_sum = 16'(l2) + 16'(h2);
  assign de_clip = (de_sum >= 16'(h_eff)) ? 16'(h_eff) - 16'd1 : de_sum;

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      column <= item.column;
    end
    if (cmd.div_start) begin
      sel_q <= cmd.div_sel;
      if (cmd.div_sel == DIV_PERP) begin
        hit <= 1'b1;
      end
    end
    if (div_done) begin
      case (sel_q)
        DIV_CAM:  cam  <= signed'(quo[29:0]) - 30'sd65536;
        DIV_DX:   ddx  <= sat24(quo);
        DIV_DY:   ddy  <= sat24(quo);
        DIV_PERP: perp <= sat24(quo);
        DIV_LH:   lh   <= (quo > DVW'(HEIGHT_MAX)) ? HEIGHT_MAX : quo[15:0];
        default:  ;
      endcase
    end
    if (cmd.ray) begin
      rx <= 32'((46'(dir_x) <<< 2) + (prod_x >>> 14));
      ry <= 32'((46'(dir_y) <<< 2) + (prod_y >>> 14));
    end
    if (cmd.side_init) begin
      sdx    <= SW'(side_px[40:16]);
      sdy    <= SW'(side_py[40:16]);
      mx     <= IW'(signed'({1'b0, pos_x[20:16]}));
      my     <= IW'(signed'({1'b0, pos_y[20:16]}));
      in_map <= (32'(pos_x[20:16]) < MAP_DIM) && (32'(pos_y[20:16]) < MAP_DIM);
      n      <= '0;
      hit    <= 1'b0;
      side   <= 1'b0;
    end
    if (cmd.step) begin
      n <= n + NW'(1);
      if (sdx < sdy) begin
        sdx  <= sdx + SW'(ddx);
        mx   <= rx[31] ? mx - IW'(1) : mx + IW'(1);
        side <= 1'b0;
      end else begin
        sdy  <= sdy + SW'(ddy);
        my   <= ry[31] ? my - IW'(1) : my + IW'(1);
        side <= 1'b1;
      end
    end
    if (cmd.miss) begin
      hit  <= 1'b0;
      side <= 1'b0;
      mx   <= '0;
      my   <= '0;
      perp <= DIST_MAX;
      lh   <= '0;
    end
    if (cmd.draw) begin
      ds <= (15'(h2) > l2) ? h2 - 11'(l2) : 11'd0;
      de <= (de_clip > 16'(ROW_MAX)) ? ROW_MAX : de_clip[10:0];
    end
    if (cmd.out_load) begin
      result.out_column  <= column;
      result.hit         <= hit;
      result.hit_side    <= side;
      result.hit_x       <= 5'($unsigned(mx));
      result.hit_y       <= 5'($unsigned(my));
      result.perp_dist   <= perp;
      result.line_height <= lh;
      result.draw_start  <= ds;
      result.draw_end    <= de;
    end
  end

  // Wall map memory with its clearing pass after reset.
  logic          wall_mem [CELLS];
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] rd_addr, cell_addr, waddr;
  logic          cell_ok, mem_we, wdata, rd_data;

  assign cell_ok   = (32'(item.cell_x) < MAP_DIM) && (32'(item.cell_y) < MAP_DIM);
  assign cell_addr = AW'(32'(item.cell_y) * MAP_DIM + 32'(item.cell_x));
  assign rd_addr   = AW'(32'($unsigned(my)) * MAP_DIM + 32'($unsigned(mx)));
  assign mem_we    = cmd.clr_en || (cmd.map_wr && cell_ok);
  assign waddr     = cmd.clr_en ? clr_cnt : cell_addr;
  assign wdata     = cmd.clr_en ? 1'b0 : item.wall_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data <= wall_mem[rd_addr];
    end
  end

  always_comb begin
    st.clr_last = clr_cnt == AW'(CELLS - 1);
    st.div_done = div_done;
    st.in_map   = in_map;
    st.oob      = mx[IW-1] || my[IW-1] ||
                  (mx >= $signed(IW'(MAP_DIM))) || (my >= $signed(IW'(MAP_DIM)));
    st.wall     = rd_data;
    st.walk_end = n == NW'(WALK_LIM);
  end

endmodule

/* rtl/core/gdr_ctrl.sv */
// Controller state machine that sequences map writes, ray setup, the walk and the result.
module gdr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_mode,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  gdr_pkg::status_t st,
  output gdr_pkg::cmd_t    cmd
);

  import gdr_pkg::*;

  typedef enum logic [20:0] {
    S_CLEAR  = 21'h000001,
    S_IDLE   = 21'h000002,
    S_CAM    = 21'h000004,
    S_CAM_W  = 21'h000008,
    S_RAY    = 21'h000010,
    S_DX     = 21'h000020,
    S_DX_W   = 21'h000040,
    S_DY     = 21'h000080,
    S_DY_W   = 21'h000100,
    S_SIDE   = 21'h000200,
    S_MAPCHK = 21'h000400,
    S_STEP   = 21'h000800,
    S_BOUND  = 21'h001000,
    S_RD     = 21'h002000,
    S_MISS   = 21'h004000,
    S_PERP   = 21'h008000,
    S_PERP_W = 21'h010000,
    S_LH     = 21'h020000,
    S_LH_W   = 21'h040000,
    S_DRAW   = 21'h080000,
    S_OUT    = 21'h100000
  } state_t;

  state_t state, state_next;
  logic   accept, out_free;

  assign item_stall = state != S_IDLE;
  assign accept     = item_valid && (state == S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_CAM;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (item_mode) begin
            cmd.cap_item = 1'b1;
            state_next   = S_CAM;
          end else begin
            cmd.map_wr = 1'b1;
          end
        end
      end
      S_CAM: begin
        cmd.div_start = 1'b1;
        state_next    = S_CAM_W;
      end
      S_CAM_W: begin
        if (st.div_done) state_next = S_RAY;
      end
      S_RAY: begin
        cmd.ray    = 1'b1;
        state_next = S_DX;
      end
      S_DX: begin
        cmd.div_sel   = DIV_DX;
        cmd.div_start = 1'b1;
        state_next    = S_DX_W;
      end
      S_DX_W: begin
        if (st.div_done) state_next = S_DY;
      end
      S_DY: begin
        cmd.div_sel   = DIV_DY;
        cmd.div_start = 1'b1;
        state_next    = S_DY_W;
      end
      S_DY_W: begin
        if (st.div_done) state_next = S_SIDE;
      end
      S_SIDE: begin
        cmd.side_init = 1'b1;
        state_next    = S_MAPCHK;
      end
      S_MAPCHK: begin
        state_next = st.in_map ? S_STEP : S_MISS;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_BOUND;
      end
      S_BOUND: begin
        if (st.oob) begin
          state_next = S_MISS;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (st.wall) begin
          state_next = S_PERP;
        end else if (st.walk_end) begin
          state_next = S_MISS;
        end else begin
          state_next = S_STEP;
        end
      end
      S_MISS: begin
        cmd.miss   = 1'b1;
        state_next = S_DRAW;
      end
      S_PERP: begin
        cmd.div_sel   = DIV_PERP;
        cmd.div_start = 1'b1;
        state_next    = S_PERP_W;
      end
      S_PERP_W: begin
        if (st.div_done) state_next = S_LH;
      end
      S_LH: begin
        cmd.div_sel   = DIV_LH;
        cmd.div_start = 1'b1;
        state_next    = S_LH_W;
      end
      S_LH_W: begin
        if (st.div_done) state_next = S_DRAW;
      end
      S_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // A quotient only arrives while the sequencer waits for one.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_CAM_W || state == S_DX_W || state == S_DY_W ||
                     state == S_PERP_W || state == S_LH_W))
    else $error("divider finished outside a wait state");

  // The result register is never overwritten while its word is held.
  a_out_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  // An accepted cast starts the camera division next.
  a_cast_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item_mode) |=> (state == S_CAM))
    else $error("cast word did not start the ray setup");

endmodule

/* rtl/core/grid_dda_column_raycaster_unit.sv */
// Top level of the grid DDA column raycaster: controller, datapath and ports.
//
//   channel   direction  handshake                  word
//   item      in         item_valid / item_stall    gdr_pkg::item_t
//   result    out        result_valid / result_stall gdr_pkg::result_t
//   cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// After reset the wall map is cleared one cell per cycle, all MAP_DIM*MAP_DIM cells
// (1024 at MAP_DIM 32); item_stall stays high through that pass, while configuration
// writes are taken at any time. A map write word is stored as it is accepted. A cast
// word holds the input until its result is loaded into the result register; a cast
// that misses skips the distance and height divisions. A walk takes at most
// 2*MAP_DIM+2 grid steps, and the divider is DVW bits wide (40 at MAP_DIM 32):
// the divisions run on one shared divider that resolves one bit per cycle, and each
// walk step passes through the step, the bounds test and the registered map read.
// A finished result waits in its own register, so the next word is accepted while
// result_stall holds the previous one; the block only waits for that register when
// the following result is ready to load.
module grid_dda_column_raycaster_unit #(
  parameter int MAP_DIM = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  gdr_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output gdr_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [gdr_pkg::CFG_W-1:0] cfg_data
);

  import gdr_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t st;

  gdr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_mode    (item.mode),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // The datapath holds the registers, the map memory and the shared divider.
  gdr_dp #(
    .MAP_DIM (MAP_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .st        (st),
    .result    (result)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the grid DDA column raycaster: directed table, then random words.
module tb_top;
  import gdr_pkg::*;

  localparam int MAP_DIM = 32;
  localparam int DRAIN_CYCLES = 700;

  logic clk, rst;
  logic item_valid, item_stall;
  item_t item;
  logic result_valid, result_stall;
  result_t result;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  grid_dda_column_raycaster_unit #(.MAP_DIM(MAP_DIM)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The predictor keeps its own copy of the registers and of the wall map.
  logic [20:0] view_x, view_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [11:0] scr_w, scr_h;
  bit wall_grid [MAP_DIM][MAP_DIM];

  result_t pending_results[$];
  int errors, casts, hits, misses, cell_writes;
  int send_idle_pct, recv_idle_pct;
  bit hold_request;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // A fixed upper bound on the run; the slowest correct run is far below it.
  initial begin
    #60000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reciprocal of a ray component in Q8.16, saturated to 24 bits, also when the component is zero.
  function automatic longint unsigned ray_delta(longint r);
    longint unsigned a, q;
    a = (r < 0) ? -r : r;
    if (a == 0) return 24'hFFFFFF;
    q = (64'd1 << 32) / a;
    return (q > 24'hFFFFFF) ? 24'hFFFFFF : q;
  endfunction

  // Distance from the viewer to the crossed cell edge, divided by the ray component.
  function automatic longint unsigned edge_dist(longint span, longint r);
    longint unsigned a, q;
    a = (r < 0) ? -r : r;
    if (a == 0) return 24'hFFFFFF;
    if (span < 0) span = -span;
    q = (unsigned'(span) << 16) / a;
    return (q > 24'hFFFFFF) ? 24'hFFFFFF : q;
  endfunction

  // Casts the ray of one column over the current map and registers.
  function automatic result_t cast_column(logic [10:0] col);
    longint w, h, cam, rx, ry, mx, my, stx, sty, px, py, ds, de, half;
    longint unsigned ddx, ddy, sdx, sdy, perp, lh, fx, fy;
    int side;
    bit hit;
    result_t r;
    w = (scr_w != 0) ? longint'(scr_w) : 1;
    h = (scr_h != 0) ? longint'(scr_h) : 1;
    px = longint'(view_x);
    py = longint'(view_y);
    cam = ((longint'(col) * 2) <<< 16) / w - 65536;
    rx = longint'(dir_x) * 4 + ((longint'(plane_x) * cam) >>> 14);
    ry = longint'(dir_y) * 4 + ((longint'(plane_y) * cam) >>> 14);
    ddx = ray_delta(rx);
    ddy = ray_delta(ry);
    mx = px >>> 16;
    my = py >>> 16;
    fx = px & 16'hFFFF;
    fy = py & 16'hFFFF;
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sdx = (((rx < 0) ? fx : 65536 - fx) * ddx) >> 16;
    sdy = (((ry < 0) ? fy : 65536 - fy) * ddy) >> 16;
    perp = 24'hFFFFFF;
    lh = 0;
    side = 0;
    hit = 0;
    if (mx < MAP_DIM && my < MAP_DIM) begin
      for (int n = 0; n < 2 * MAP_DIM + 2; n++) begin
        if (sdx < sdy) begin
          sdx += ddx;
          mx += stx;
          side = 0;
        end else begin
          sdy += ddy;
          my += sty;
          side = 1;
        end
        if (mx < 0 || mx >= MAP_DIM || my < 0 || my >= MAP_DIM) break;
        if (wall_grid[my][mx]) begin
          hit = 1;
          break;
        end
      end
    end
    if (hit) begin
      if (side == 0)
        perp = edge_dist((stx > 0) ? mx * 65536 - px : px - (mx + 1) * 65536, rx);
      else
        perp = edge_dist((sty > 0) ? my * 65536 - py : py - (my + 1) * 65536, ry);
      if (perp == 0) lh = 16'hFFFF;
      else begin
        lh = (unsigned'(h) << 16) / perp;
        if (lh > 16'hFFFF) lh = 16'hFFFF;
      end
    end else begin
      side = 0;
      mx = 0;
      my = 0;
    end
    half = longint'(lh >> 1);
    ds = h / 2 - half;
    if (ds < 0) ds = 0;
    de = half + h / 2;
    if (de >= h) de = h - 1;
    if (ds > 2047) ds = 2047;
    if (de > 2047) de = 2047;
    r.out_column = col;
    r.hit = hit;
    r.hit_side = side[0];
    r.hit_x = mx[4:0];
    r.hit_y = my[4:0];
    r.perp_dist = perp[23:0];
    r.line_height = lh[15:0];
    r.draw_start = ds[10:0];
    r.draw_end = de[10:0];
    return r;
  endfunction

  // Offers one word, waits for the handshake, then updates the predictor.
  // When use_typed is set the typed-in result is expected instead of the prediction.
  task automatic send_word(item_t it, bit use_typed, result_t typed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    if (it.mode) begin
      pending_results.push_back(use_typed ? typed : cast_column(it.column));
      casts++;
    end else begin
      wall_grid[it.cell_y][it.cell_x] = it.wall_bit;
      cell_writes++;
    end
  endtask

  // Stops offering and waits until every cast has come back, plus a margin
  // for a cell write or a cast that might still be in flight.
  task automatic drain;
    int guard;
    @(negedge clk);
    item_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POS_X:   view_x = val[20:0];
      REG_POS_Y:   view_y = val[20:0];
      REG_DIR_X:   dir_x = val[15:0];
      REG_DIR_Y:   dir_y = val[15:0];
      REG_PLANE_X: plane_x = val[15:0];
      REG_PLANE_Y: plane_y = val[15:0];
      REG_SCR_W:   scr_w = val[11:0];
      default:     scr_h = val[11:0];
    endcase
  endtask

  // Loads all eight registers, one per cycle, then releases the write enable.
  task automatic load_view(logic [20:0] vx, logic [20:0] vy, logic [15:0] dx, logic [15:0] dy,
                           logic [15:0] plx, logic [15:0] ply, logic [11:0] w, logic [11:0] h);
    write_reg(REG_POS_X, vx);
    write_reg(REG_POS_Y, vy);
    write_reg(REG_DIR_X, 21'(dx));
    write_reg(REG_DIR_Y, 21'(dy));
    write_reg(REG_PLANE_X, 21'(plx));
    write_reg(REG_PLANE_Y, 21'(ply));
    write_reg(REG_SCR_W, 21'(w));
    write_reg(REG_SCR_H, 21'(h));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random stalls, and once a long hold-off so the block backs up.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word for column %0d with no expectation waiting", result.out_column);
        errors++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("out_column", want.out_column, result.out_column);
        cmp_field("hit", want.hit, result.hit);
        cmp_field("hit_side", want.hit_side, result.hit_side);
        cmp_field("hit_x", want.hit_x, result.hit_x);
        cmp_field("hit_y", want.hit_y, result.hit_y);
        cmp_field("perp_dist", want.perp_dist, result.perp_dist);
        cmp_field("line_height", want.line_height, result.line_height);
        cmp_field("draw_start", want.draw_start, result.draw_start);
        cmp_field("draw_end", want.draw_end, result.draw_end);
        if (result.hit) hits++;
        else misses++;
      end
    end
  end

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } stim_row_t;

  function automatic item_t cast_word(logic [10:0] col);
    item_t it;
    it = '0;
    it.mode = 1'b1;
    it.column = col;
    return it;
  endfunction

  function automatic item_t cell_word(logic [4:0] cx, logic [4:0] cy, logic wb);
    item_t it;
    it = '0;
    it.cell_x = cx;
    it.cell_y = cy;
    it.wall_bit = wb;
    return it;
  endfunction

  // A miss from the reset view: the ray leaves an empty map, rows sit at the middle.
  function automatic result_t reset_miss(logic [10:0] col);
    result_t r;
    r.out_column = col;
    r.hit = 1'b0;
    r.hit_side = 1'b0;
    r.hit_x = '0;
    r.hit_y = '0;
    r.perp_dist = DIST_MAX;
    r.line_height = '0;
    r.draw_start = 11'd240;
    r.draw_end = 11'd240;
    return r;
  endfunction

  // Random words: mostly casts over a map kept moderately populated.
  function automatic item_t random_word();
    item_t it;
    it = 23'($urandom);
    it.mode = ($urandom_range(99) >= 35);
    if (!it.mode) it.wall_bit = ($urandom_range(99) < 30);
    return it;
  endfunction

  initial begin : stimulus
    stim_row_t table_rows[$];
    item_t it;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 0;
    errors = 0;
    casts = 0;
    hits = 0;
    misses = 0;
    cell_writes = 0;
    send_idle_pct = 10;
    recv_idle_pct = 73;
    view_x = '0;
    view_y = '0;
    dir_x = 16'sd16384;
    dir_y = '0;
    plane_x = '0;
    plane_y = 16'sd10813;
    scr_w = 12'd640;
    scr_h = 12'd480;
    foreach (wall_grid[y, x]) wall_grid[y][x] = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part: misses on the cleared map, then walls at the corners, the edges and one inner cell.
    table_rows.push_back('{cast_word(11'd0), 1, reset_miss(11'd0)});
    table_rows.push_back('{cast_word(11'd2047), 1, reset_miss(11'd2047)});
    table_rows.push_back('{cast_word(11'd320), 1, reset_miss(11'd320)});
    table_rows.push_back('{cell_word(5'd3, 5'd0, 1'b1), 0, '0});
    table_rows.push_back('{cell_word(5'd31, 5'd31, 1'b1), 0, '0});
    table_rows.push_back('{cell_word(5'd0, 5'd31, 1'b1), 0, '0});
    table_rows.push_back('{cell_word(5'd31, 5'd0, 1'b1), 0, '0});
    table_rows.push_back('{cast_word(11'd320), 0, '0});
    table_rows.push_back('{cast_word(11'd0), 0, '0});
    table_rows.push_back('{cast_word(11'd639), 0, '0});
    table_rows.push_back('{cast_word(11'd2047), 0, '0});
    table_rows.push_back('{cell_word(5'd3, 5'd0, 1'b0), 0, '0});
    table_rows.push_back('{cast_word(11'd320), 0, '0});
    table_rows.push_back('{cell_word(5'd1, 5'd0, 1'b1), 0, '0});
    table_rows.push_back('{cast_word(11'd320), 0, '0});
    table_rows.push_back('{cell_word(5'd0, 5'd0, 1'b1), 0, '0});
    table_rows.push_back('{cast_word(11'd100), 0, '0});
    // A cell write with junk in the column field, which must be ignored.
    it = cell_word(5'd21, 5'd10, 1'b1);
    it.column = 11'h7FF;
    table_rows.push_back('{it, 0, '0});
    table_rows.push_back('{cast_word(11'd1023), 0, '0});
    foreach (table_rows[i]) send_word(table_rows[i].it, table_rows[i].typed, table_rows[i].res);

    // Random part in six phases, each with its own view; the idling pattern
    // swaps after two phases and is switched off for the last two.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 73 : 0;
      recv_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 10 : 0;
      if (ph > 0) begin
        drain();
        case (ph)
          1: load_view(21'h1FFFFF, 21'h1FFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                       12'd0, 12'd0);
          2: load_view(21'h100000, 21'h100000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000,
                       12'd2048, 12'd2048);
          3: load_view(21'h000000, 21'h1FFFFF, 16'h0000, 16'hC000, 16'h2A3D, 16'h0000,
                       12'd1, 12'd1);
          default: load_view(21'($urandom), 21'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom),
                             12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)));
        endcase
      end
      // The first phase starts with a long hold-off on the result side.
      if (ph == 0) hold_request = 1;
      for (int n = 0; n < 230; n++) begin
        it = random_word();
        // Keep most columns within the configured width, a few beyond it.
        if (it.mode && $urandom_range(9) != 0 && scr_w > 1)
          it.column = 11'($urandom_range(0, (scr_w > 2048 ? 2048 : scr_w) - 1));
        send_word(it, 0, '0);
      end
    end

    drain();
    $display("Covered %0d cell writes and %0d ray casts (%0d hits, %0d misses)",
             cell_writes, casts, hits, misses);
    $display("over six register settings and three idling patterns, one long result hold-off.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
